### hw/rtl/cgqe_pkg.sv
package cgqe_pkg;

   localparam int FUNC_W = 3;
   localparam int CITY_W = 6;
   localparam int DIST_W = 16;
   localparam int CNT_W  = 7;
   localparam int LEN_W  = 17;
   localparam int CSR_W  = 7;

   localparam logic [CSR_W-1:0] CITY_COUNT_RESET = 7'd64;

   localparam logic [FUNC_W-1:0] FUNC_WRITE  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_DEGREE = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_MOST   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_ROUTE  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_GROUP  = 3'd4;

endpackage

### hw/rtl/city_graph_query_engine.sv
// city graph query engine: a symmetric table of road lengths between cities
// (zero means no road) plus a running group check
// req_ channel: one item per operation (func, city_a, city_b, distance, group_last);
// an item is taken when req_valid is high and req_stall is low
// rsp_ channel: exactly one result item per request item, in order
// csr_ port: csr_write_enable writes city_count; the user must write it only
// while the block is idle, which the block does not enforce
// after reset a clearing pass writes zero to all MAX_CITIES*MAX_CITIES table
// entries, one per cycle, with req_stall held high
// one item at a time: the table memory with two registered read ports is swept
// one column per cycle under a small sequencer
//   out-of-range or unknown items: no table access, result from the finish state
//   write: two table writes, one per direction (none when city_a equals city_b)
//   degree, route, group: one row of cities in use; most connected: every row in turn
// req_stall is low only in idle; a result item waits in the output register
// while rsp_stall is high, and the next item is accepted meanwhile, its
// result held until the output register is free
module city_graph_query_engine
   import cgqe_pkg::*;
#(
   parameter int MAX_CITIES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [CSR_W-1:0]  csr_write_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [CITY_W-1:0] req_city_a,
   input  logic [CITY_W-1:0] req_city_b,
   input  logic [DIST_W-1:0] req_distance,
   input  logic              req_group_last,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_error,
   output logic [CNT_W-1:0]  rsp_count,
   output logic [CITY_W-1:0] rsp_city,
   output logic              rsp_found,
   output logic [LEN_W-1:0]  rsp_route_length
);

   localparam int DEPTH = MAX_CITIES * MAX_CITIES;
   localparam int AW    = $clog2(DEPTH);
   localparam int IW    = $clog2(MAX_CITIES);
   localparam int CW    = $clog2(MAX_CITIES + 1);
   localparam int NW    = (CW > CNT_W) ? CW : CNT_W;

   typedef enum logic [4:0] {
      ST_CLEAR  = 5'b00001,
      ST_IDLE   = 5'b00010,
      ST_WRITE  = 5'b00100,
      ST_SCAN   = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] row,
                                             input logic [IW-1:0] col);
      addr_of = AW'(row) * AW'(MAX_CITIES) + AW'(col);
   endfunction

   // table memory
   logic [DIST_W-1:0] road_mem [DEPTH];
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [DIST_W-1:0] mem_wdata;
   logic [AW-1:0]     mem_raddr0;
   logic [AW-1:0]     mem_raddr1;
   logic [DIST_W-1:0] rd0_ff;
   logic [DIST_W-1:0] rd1_ff;

   // control state
   state_type             state_ff, state_in;
   logic [AW-1:0]         clear_ff, clear_in;
   logic [CSR_W-1:0]      city_count_ff, city_count_in;
   logic [MAX_CITIES-1:0] group_members_ff, group_members_in;
   logic                  group_failed_ff, group_failed_in;
   logic                  issue_ff, issue_in;
   logic                  p_valid_ff, p_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // operation and scan payload
   logic [FUNC_W-1:0] op_ff, op_in;
   logic [IW-1:0]     a_idx_ff, a_idx_in;
   logic [IW-1:0]     b_idx_ff, b_idx_in;
   logic [DIST_W-1:0] d_ff, d_in;
   logic              last_ff, last_in;
   logic [IW-1:0]     row_ff, row_in;
   logic [IW-1:0]     col_ff, col_in;
   logic [IW-1:0]     p_row_ff, p_row_in;
   logic [IW-1:0]     p_col_ff, p_col_in;
   logic              p_row_end_ff, p_row_end_in;
   logic              p_last_ff, p_last_in;
   logic [NW-1:0]     acc_ff, acc_in;
   logic [NW-1:0]     best_cnt_ff, best_cnt_in;
   logic [IW-1:0]     who_ff, who_in;
   logic              found_ff, found_in;
   logic [LEN_W-1:0]  len_ff, len_in;

   // finished result, then the output register
   logic              res_err_ff, res_err_in;
   logic [CNT_W-1:0]  res_cnt_ff, res_cnt_in;
   logic [CITY_W-1:0] res_city_ff, res_city_in;
   logic              res_fnd_ff, res_fnd_in;
   logic [LEN_W-1:0]  res_len_ff, res_len_in;
   logic              rsp_error_ff, rsp_error_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [CITY_W-1:0] rsp_city_ff, rsp_city_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [LEN_W-1:0]  rsp_len_ff, rsp_len_in;

   // working values
   logic [NW-1:0]    n_eff;
   logic [NW-1:0]    n_m1;
   logic             a_ok;
   logic             b_ok;
   logic             col_last;
   logic             row_last;
   logic             nz0;
   logic             nz1;
   logic [NW-1:0]    row_cnt;
   logic [NW-1:0]    best_nx;
   logic [IW-1:0]    who_nx;
   logic [LEN_W-1:0] sum;
   logic             take;
   logic             fail_nx;

   always_comb begin
      if (city_count_ff == '0) begin
         n_eff = NW'(1);
      end else if (NW'(city_count_ff) > NW'(MAX_CITIES)) begin
         n_eff = NW'(MAX_CITIES);
      end else begin
         n_eff = NW'(city_count_ff);
      end
   end

   assign n_m1 = n_eff - NW'(1);
   assign a_ok = NW'(req_city_a) < n_eff;
   assign b_ok = NW'(req_city_b) < n_eff;

   assign mem_raddr0 = addr_of(row_ff, col_ff);
   assign mem_raddr1 = addr_of(b_idx_ff, col_ff);

   assign nz0     = rd0_ff != '0;
   assign nz1     = rd1_ff != '0;
   assign row_cnt = acc_ff + NW'(nz0);
   assign sum     = LEN_W'(rd0_ff) + LEN_W'(rd1_ff);

   always_comb begin
      state_in         = state_ff;
      clear_in         = clear_ff;
      city_count_in    = city_count_ff;
      group_members_in = group_members_ff;
      group_failed_in  = group_failed_ff;
      issue_in         = issue_ff;
      p_valid_in       = 1'b0;
      op_in            = op_ff;
      a_idx_in         = a_idx_ff;
      b_idx_in         = b_idx_ff;
      d_in             = d_ff;
      last_in          = last_ff;
      row_in           = row_ff;
      col_in           = col_ff;
      p_row_in         = p_row_ff;
      p_col_in         = p_col_ff;
      p_row_end_in     = p_row_end_ff;
      p_last_in        = p_last_ff;
      acc_in           = acc_ff;
      best_cnt_in      = best_cnt_ff;
      who_in           = who_ff;
      found_in         = found_ff;
      len_in           = len_ff;
      res_err_in       = res_err_ff;
      res_cnt_in       = res_cnt_ff;
      res_city_in      = res_city_ff;
      res_fnd_in       = res_fnd_ff;
      res_len_in       = res_len_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_error_in     = rsp_error_ff;
      rsp_count_in     = rsp_count_ff;
      rsp_city_in      = rsp_city_ff;
      rsp_found_in     = rsp_found_ff;
      rsp_len_in       = rsp_len_ff;
      mem_we           = 1'b0;
      mem_waddr        = '0;
      mem_wdata        = '0;
      col_last         = 1'b0;
      row_last         = 1'b0;
      best_nx          = best_cnt_ff;
      who_nx           = who_ff;
      take             = 1'b0;
      fail_nx          = group_failed_ff;

      if (csr_write_enable) begin
         city_count_in = csr_write_data;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clear_ff;
            clear_in  = clear_ff + AW'(1);
            if (clear_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in       = req_func;
               a_idx_in    = IW'(req_city_a);
               b_idx_in    = IW'(req_city_b);
               d_in        = req_distance;
               last_in     = req_group_last;
               res_err_in  = 1'b0;
               res_cnt_in  = '0;
               res_city_in = '0;
               res_fnd_in  = 1'b0;
               res_len_in  = '0;
               row_in      = IW'(req_city_a);
               col_in      = '0;
               acc_in      = '0;
               best_cnt_in = '0;
               who_in      = '0;
               found_in    = 1'b0;
               len_in      = '0;
               issue_in    = 1'b1;
               state_in    = ST_FINISH;
               case (req_func) inside
                  FUNC_WRITE: begin
                     if (!a_ok || !b_ok) begin
                        res_err_in = 1'b1;
                     end else if (req_city_a != req_city_b) begin
                        mem_we    = 1'b1;
                        mem_waddr = addr_of(IW'(req_city_a), IW'(req_city_b));
                        mem_wdata = req_distance;
                        state_in  = ST_WRITE;
                     end
                  end
                  FUNC_DEGREE, FUNC_GROUP: begin
                     if (!a_ok) begin
                        res_err_in = 1'b1;
                        if (req_func == FUNC_GROUP && req_group_last) begin
                           group_members_in = '0;
                           group_failed_in  = 1'b0;
                        end
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  FUNC_MOST: begin
                     row_in   = '0;
                     state_in = ST_SCAN;
                  end
                  FUNC_ROUTE: begin
                     if (!a_ok || !b_ok) begin
                        res_err_in = 1'b1;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = addr_of(b_idx_ff, a_idx_ff);
            mem_wdata = d_ff;
            state_in  = ST_FINISH;
         end
         ST_SCAN: begin
            // issue side: one column address per cycle
            if (issue_ff) begin
               col_last     = NW'(col_ff) == n_m1;
               row_last     = (op_ff != FUNC_MOST) || (NW'(row_ff) == n_m1);
               p_valid_in   = 1'b1;
               p_row_in     = row_ff;
               p_col_in     = col_ff;
               p_row_end_in = col_last;
               p_last_in    = col_last && row_last;
               col_in       = col_ff + IW'(1);
               if (col_last) begin
                  col_in = '0;
                  row_in = row_ff + IW'(1);
                  if (row_last) begin
                     issue_in = 1'b0;
                  end
               end
            end
            // data side: read data of the column issued last cycle
            if (p_valid_ff) begin
               case (op_ff)
                  FUNC_DEGREE: begin
                     acc_in = row_cnt;
                     if (p_last_ff) begin
                        res_cnt_in = CNT_W'(row_cnt);
                     end
                  end
                  FUNC_MOST: begin
                     acc_in = row_cnt;
                     if (p_row_end_ff) begin
                        acc_in = '0;
                        if (row_cnt > best_cnt_ff) begin
                           best_nx = row_cnt;
                           who_nx  = p_row_ff;
                        end
                     end
                     best_cnt_in = best_nx;
                     who_in      = who_nx;
                     if (p_last_ff) begin
                        res_cnt_in  = CNT_W'(best_nx);
                        res_city_in = CITY_W'(who_nx);
                     end
                  end
                  FUNC_ROUTE: begin
                     // strict minimum keeps the lowest middle city on a tie
                     take = nz0 && nz1 && (!found_ff || sum < len_ff);
                     if (take) begin
                        found_in = 1'b1;
                        len_in   = sum;
                        who_in   = p_col_ff;
                     end
                     if (p_last_ff) begin
                        res_fnd_in  = found_ff || take;
                        res_city_in = take ? CITY_W'(p_col_ff) : CITY_W'(who_ff);
                        res_len_in  = take ? sum : len_ff;
                     end
                  end
                  FUNC_GROUP: begin
                     // the diagonal is always zero, so a repeated member fails here too
                     fail_nx         = group_failed_ff ||
                                       (group_members_ff[p_col_ff] && !nz0);
                     group_failed_in = fail_nx;
                     if (p_last_ff) begin
                        res_fnd_in                 = !fail_nx;
                        group_members_in[a_idx_ff] = 1'b1;
                        if (last_ff) begin
                           group_members_in = '0;
                           group_failed_in  = 1'b0;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
               if (p_last_ff) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_error_in = res_err_ff;
               rsp_count_in = res_cnt_ff;
               rsp_city_in  = res_city_ff;
               rsp_found_in = res_fnd_ff;
               rsp_len_in   = res_len_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         road_mem[mem_waddr] <= mem_wdata;
      end
      rd0_ff <= road_mem[mem_raddr0];
      rd1_ff <= road_mem[mem_raddr1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         clear_ff         <= '0;
         city_count_ff    <= CITY_COUNT_RESET;
         group_members_ff <= '0;
         group_failed_ff  <= 1'b0;
         issue_ff         <= 1'b0;
         p_valid_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         clear_ff         <= clear_in;
         city_count_ff    <= city_count_in;
         group_members_ff <= group_members_in;
         group_failed_ff  <= group_failed_in;
         issue_ff         <= issue_in;
         p_valid_ff       <= p_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      a_idx_ff     <= a_idx_in;
      b_idx_ff     <= b_idx_in;
      d_ff         <= d_in;
      last_ff      <= last_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      p_row_ff     <= p_row_in;
      p_col_ff     <= p_col_in;
      p_row_end_ff <= p_row_end_in;
      p_last_ff    <= p_last_in;
      acc_ff       <= acc_in;
      best_cnt_ff  <= best_cnt_in;
      who_ff       <= who_in;
      found_ff     <= found_in;
      len_ff       <= len_in;
      res_err_ff   <= res_err_in;
      res_cnt_ff   <= res_cnt_in;
      res_city_ff  <= res_city_in;
      res_fnd_ff   <= res_fnd_in;
      res_len_ff   <= res_len_in;
      rsp_error_ff <= rsp_error_in;
      rsp_count_ff <= rsp_count_in;
      rsp_city_ff  <= rsp_city_in;
      rsp_found_ff <= rsp_found_in;
      rsp_len_ff   <= rsp_len_in;
   end

   assign req_stall        = state_ff != ST_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_error        = rsp_error_ff;
   assign rsp_count        = rsp_count_ff;
   assign rsp_city         = rsp_city_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_route_length = rsp_len_ff;

endmodule

### hw/rtl/cgqe_checker.sv
module cgqe_checker
   import cgqe_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              csr_write_enable,
   input logic [CSR_W-1:0]  csr_write_data,
   input logic              req_valid,
   input logic              req_stall,
   input logic [FUNC_W-1:0] req_func,
   input logic [CITY_W-1:0] req_city_a,
   input logic [CITY_W-1:0] req_city_b,
   input logic [DIST_W-1:0] req_distance,
   input logic              req_group_last,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic              rsp_error,
   input logic [CNT_W-1:0]  rsp_count,
   input logic [CITY_W-1:0] rsp_city,
   input logic              rsp_found,
   input logic [LEN_W-1:0]  rsp_route_length
);

   // clearing pass holds off items right after reset
   assert property (@(posedge clock) reset |=> req_stall)
      else $error("req_stall low right after reset");

   // one item at a time: busy right after an accept
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item accepted while a previous item is at work");

   // stalled result item holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_error) &&
         $stable(rsp_count) && $stable(rsp_city) && $stable(rsp_found) &&
         $stable(rsp_route_length)))
      else $error("stalled result item changed");

   // an error result carries nothing else
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error) |-> (rsp_count == '0 && rsp_city == '0 &&
         !rsp_found && rsp_route_length == '0))
      else $error("error result with nonzero fields");

   // no route length without a found route
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_route_length == '0))
      else $error("route length given without a route");

endmodule

bind city_graph_query_engine cgqe_checker u_cgqe_checker (.*);
